// ----- rtl/core/rate_monotonic_task_scheduler_defines.svh -----
// Assertion macros for the rate monotonic task scheduler.
`ifndef RATE_MONOTONIC_TASK_SCHEDULER_DEFINES_SVH
`define RATE_MONOTONIC_TASK_SCHEDULER_DEFINES_SVH
`ifndef SYNTH
`define RMTS_ASSERT_NOW(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define RMTS_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define RMTS_ASSERT_NOW(label, clk, rst_n, a, c, msg)
`define RMTS_ASSERT_NEXT(label, clk, rst_n, a, c, msg)
`endif
`endif

// ----- rtl/core/rmts_pkg.sv -----
// Shared types and constants of the rate monotonic task scheduler.
`timescale 1ns / 1ps
package rmts_pkg;

    localparam int ID_W     = 22;
    localparam int PER_W    = 16;
    localparam int COMP_W   = 16;
    localparam int SHARE_W  = 17;
    localparam int TOTAL_W  = 21;
    localparam int TIME_W   = 48;
    localparam int LIMIT_W  = 10;
    localparam int DVD_W    = 32;
    localparam int STEP_W   = 5;

    localparam logic [SHARE_W-1:0] SHARE_MAX   = 17'h1FFFF;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd693;
    localparam logic [31:0]        UTIL_SCALE  = 32'd1000;

    typedef enum logic [1:0] {
        OP_REGISTER   = 2'd0,
        OP_YIELD      = 2'd1,
        OP_DEREGISTER = 2'd2,
        OP_TICK       = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MODE_SLEEP = 2'd0,
        MODE_READY = 2'd1,
        MODE_RUN   = 2'd2,
        MODE_NEW   = 2'd3
    } mode_t;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_REFUSED  = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [PER_W-1:0]   period;
        logic [SHARE_W-1:0] share;
        logic [TIME_W-1:0]  deadline;
    } entry_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_res_t;

endpackage

// ----- rtl/core/rmts_div.sv -----
// Restoring divider, one quotient bit per cycle, for task utilization.
`timescale 1ns / 1ps
module rmts_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [rmts_pkg::DVD_W-1:0]      dividend,
    input  logic [rmts_pkg::PER_W-1:0]      divisor,
    output rmts_pkg::div_res_t              res
);
    import rmts_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [DVD_W-1:0]    quo_reg, quo_next;
    logic [PER_W-1:0]    rem_reg, rem_next;
    logic [PER_W-1:0]    dsr_reg, dsr_next;
    logic [PER_W:0]      trial;
    logic [PER_W:0]      diff;
    logic                ge;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[DVD_W-1]};
        ge        = trial >= {1'b0, dsr_reg};
        diff      = trial - {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[DVD_W-2:0], ge};
            rem_next  = ge ? diff[PER_W-1:0] : trial[PER_W-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign res.done     = done_reg;
    assign res.quotient = quo_reg;

endmodule

// ----- rtl/core/rate_monotonic_task_scheduler.sv -----
// Top level of the rate monotonic task scheduler.
`timescale 1ns / 1ps
// Periodic task table with rate monotonic dispatch and utilization admission.
// One transaction is taken at a time; each gives exactly one result. Task
// entries live in a slot memory (one read, one write per cycle, registered
// read) plus a small mode memory; used bits sit in flip-flops. A register
// runs a free slot search over the used bits, then a 32-step divider for
// the share, then the admission multiply. Yield and tick make one pass over
// the slot memory to find the task or wake sleepers, then a second pass for
// dispatch (for tick only if a task woke), one slot per cycle. Deregister
// makes one pass to find the task. A result may wait on out_ready; the next
// transaction is taken once it has been loaded.
`include "rate_monotonic_task_scheduler_defines.svh"
module rate_monotonic_task_scheduler #(
    parameter int TASK_SLOTS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    operation,
    input  logic [rmts_pkg::ID_W-1:0]     task_id,
    input  logic [rmts_pkg::PER_W-1:0]    period,
    input  logic [rmts_pkg::COMP_W-1:0]   computation,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    status,
    output logic                          running_valid,
    output logic [rmts_pkg::ID_W-1:0]     running_id,
    output logic                          switched,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rmts_pkg::LIMIT_W-1:0]  cfg_data
);
    import rmts_pkg::*;

    localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CW = $clog2(TASK_SLOTS + 1);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_FREE   = 12'b000000000010,
        S_DIV    = 12'b000000000100,
        S_ADMIT  = 12'b000000001000,
        S_COMMIT = 12'b000000010000,
        S_FIND   = 12'b000000100000,
        S_UPDATE = 12'b000001000000,
        S_TICK   = 12'b000010000000,
        S_DISP   = 12'b000100000000,
        S_SWAP1  = 12'b001000000000,
        S_SWAP2  = 12'b010000000000,
        S_DONE   = 12'b100000000000
    } state_t;

    // slot memories
    entry_t info_mem [TASK_SLOTS];
    mode_t  mode_mem [TASK_SLOTS];
    entry_t rd_info;
    mode_t  rd_mode;
    logic [IW-1:0] rd_addr;
    logic          info_we;
    logic [IW-1:0] info_waddr;
    entry_t        info_wdata;
    logic          mode_we;
    logic [IW-1:0] mode_waddr;
    mode_t         mode_wdata;

    state_t               state_reg, state_next;
    logic [1:0]           op_reg, op_next;
    logic [ID_W-1:0]      id_reg, id_next;
    logic [PER_W-1:0]     per_reg, per_next;
    logic [COMP_W-1:0]    comp_reg, comp_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 pend_reg, pend_next;
    logic [IW-1:0]        pidx_reg, pidx_next;
    logic                 found_reg, found_next;
    logic [IW-1:0]        slot_reg, slot_next;
    entry_t               ent_reg, ent_next;
    mode_t                fmode_reg, fmode_next;
    logic                 bfound_reg, bfound_next;
    logic [IW-1:0]        best_reg, best_next;
    logic [PER_W-1:0]     bper_reg, bper_next;
    logic [ID_W-1:0]      bid_reg, bid_next;
    logic                 woke_reg, woke_next;
    logic [SHARE_W-1:0]   share_reg, share_next;
    logic [31:0]          prod_reg, prod_next;
    logic [TOTAL_W-1:0]   total_reg, total_next;
    logic [TASK_SLOTS-1:0] used_reg, used_next;
    logic                 rvalid_reg, rvalid_next;
    logic [IW-1:0]        rslot_reg, rslot_next;
    logic [ID_W-1:0]      rid_reg, rid_next;
    logic [TIME_W-1:0]    time_reg, time_next;
    logic [LIMIT_W-1:0]   limit_reg, limit_next;
    logic [1:0]           st_reg, st_next;
    logic                 sw_reg, sw_next;
    logic                 ovalid_reg, ovalid_next;
    logic [1:0]           ost_reg, ost_next;
    logic                 orv_reg, orv_next;
    logic [ID_W-1:0]      oid_reg, oid_next;
    logic                 osw_reg, osw_next;

    logic                 scan_issue;
    logic                 scan_end;
    logic [TOTAL_W:0]     sum;
    logic                 div_start;
    div_res_t             div_res;
    entry_t               upd;
    mode_t                upd_mode;

    rmts_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({comp_reg, 16'b0}),
        .divisor  (per_reg),
        .res      (div_res)
    );

    always_ff @(posedge clk)
    begin
        rd_info <= info_mem[rd_addr];
        rd_mode <= mode_mem[rd_addr];
        if (info_we)
        begin
            info_mem[info_waddr] <= info_wdata;
        end
        if (mode_we)
        begin
            mode_mem[mode_waddr] <= mode_wdata;
        end
    end

    assign scan_issue = cnt_reg < CW'(TASK_SLOTS);
    assign scan_end   = !scan_issue && !pend_reg;
    assign rd_addr    = scan_issue ? cnt_reg[IW-1:0] : '0;
    assign sum        = (TOTAL_W+1)'(total_reg) + (TOTAL_W+1)'(share_reg);

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        id_next     = id_reg;
        per_next    = per_reg;
        comp_next   = comp_reg;
        cnt_next    = cnt_reg;
        pend_next   = pend_reg;
        pidx_next   = pidx_reg;
        found_next  = found_reg;
        slot_next   = slot_reg;
        ent_next    = ent_reg;
        fmode_next  = fmode_reg;
        bfound_next = bfound_reg;
        best_next   = best_reg;
        bper_next   = bper_reg;
        bid_next    = bid_reg;
        woke_next   = woke_reg;
        share_next  = share_reg;
        prod_next   = prod_reg;
        total_next  = total_reg;
        used_next   = used_reg;
        rvalid_next = rvalid_reg;
        rslot_next  = rslot_reg;
        rid_next    = rid_reg;
        time_next   = time_reg;
        limit_next  = cfg_valid ? cfg_data : limit_reg;
        st_next     = st_reg;
        sw_next     = sw_reg;
        ovalid_next = ovalid_reg && !out_ready;
        ost_next    = ost_reg;
        orv_next    = orv_reg;
        oid_next    = oid_reg;
        osw_next    = osw_reg;
        div_start   = 1'b0;
        info_we     = 1'b0;
        info_waddr  = slot_reg;
        info_wdata  = ent_reg;
        mode_we     = 1'b0;
        mode_waddr  = slot_reg;
        mode_wdata  = MODE_READY;
        upd         = ent_reg;
        upd_mode    = fmode_reg;

        // memory scans: issue one read a cycle, handle its data the next
        if (state_reg == S_FIND || state_reg == S_TICK || state_reg == S_DISP)
        begin
            pend_next = scan_issue;
            pidx_next = rd_addr;
            if (scan_issue)
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = operation;
                    id_next     = task_id;
                    per_next    = period;
                    comp_next   = computation;
                    st_next     = ST_OK;
                    sw_next     = 1'b0;
                    cnt_next    = '0;
                    pend_next   = 1'b0;
                    found_next  = 1'b0;
                    bfound_next = 1'b0;
                    woke_next   = 1'b0;
                    case (op_t'(operation))
                        OP_REGISTER:   state_next = S_FREE;
                        OP_YIELD:      state_next = S_FIND;
                        OP_DEREGISTER: state_next = S_FIND;
                        default:
                        begin
                            time_next  = time_reg + 1'b1;
                            state_next = S_TICK;
                        end
                    endcase
                end
            end
            S_FREE:
            begin
                if (scan_issue)
                begin
                    if (!used_reg[rd_addr])
                    begin
                        slot_next  = rd_addr;
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                else
                begin
                    st_next    = ST_FULL;
                    state_next = S_DONE;
                end
            end
            S_DIV:
            begin
                if (div_res.done)
                begin
                    share_next = (div_res.quotient[DVD_W-1:SHARE_W] != '0) ? SHARE_MAX
                                 : div_res.quotient[SHARE_W-1:0];
                    state_next = S_ADMIT;
                end
            end
            S_ADMIT:
            begin
                prod_next  = 32'(sum) * UTIL_SCALE;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (prod_reg > (32'(limit_reg) << 16))
                begin
                    st_next = ST_REFUSED;
                end
                else
                begin
                    total_next          = sum[TOTAL_W-1:0];
                    used_next[slot_reg] = 1'b1;
                    info_we             = 1'b1;
                    info_wdata.id       = id_reg;
                    info_wdata.period   = per_reg;
                    info_wdata.share    = share_reg;
                    info_wdata.deadline = '0;
                    mode_we             = 1'b1;
                    mode_wdata          = MODE_NEW;
                end
                state_next = S_DONE;
            end
            S_FIND:
            begin
                if (pend_reg && used_reg[pidx_reg] && rd_info.id == id_reg && !found_reg)
                begin
                    found_next = 1'b1;
                    slot_next  = pidx_reg;
                    ent_next   = rd_info;
                    fmode_next = rd_mode;
                end
                if (scan_end)
                begin
                    if (!found_reg)
                    begin
                        st_next    = ST_NOTFOUND;
                        state_next = S_DONE;
                    end
                    else if (op_t'(op_reg) == OP_YIELD)
                    begin
                        state_next = S_UPDATE;
                    end
                    else
                    begin
                        if (rvalid_reg && rslot_reg == slot_reg)
                        begin
                            rvalid_next = 1'b0;
                        end
                        total_next = (total_reg >= TOTAL_W'(ent_reg.share))
                                     ? total_reg - TOTAL_W'(ent_reg.share) : '0;
                        used_next[slot_reg] = 1'b0;
                        state_next = S_DONE;
                    end
                end
            end
            S_UPDATE:
            begin
                if (fmode_reg == MODE_NEW)
                begin
                    upd.deadline = time_reg + TIME_W'(ent_reg.period);
                    upd_mode     = MODE_READY;
                end
                else
                begin
                    if (time_reg < ent_reg.deadline)
                    begin
                        upd_mode = MODE_SLEEP;
                        if (rvalid_reg && rslot_reg == slot_reg)
                        begin
                            rvalid_next = 1'b0;
                        end
                    end
                    upd.deadline = ent_reg.deadline + TIME_W'(ent_reg.period);
                end
                info_we    = 1'b1;
                info_wdata = upd;
                mode_we    = 1'b1;
                mode_wdata = upd_mode;
                cnt_next   = '0;
                pend_next  = 1'b0;
                state_next = S_DISP;
            end
            S_TICK:
            begin
                if (pend_reg && used_reg[pidx_reg] && rd_mode == MODE_SLEEP &&
                    (rd_info.deadline - TIME_W'(rd_info.period)) <= time_reg)
                begin
                    mode_we    = 1'b1;
                    mode_waddr = pidx_reg;
                    mode_wdata = MODE_READY;
                    woke_next  = 1'b1;
                end
                if (scan_end)
                begin
                    cnt_next   = '0;
                    state_next = woke_reg ? S_DISP : S_DONE;
                end
            end
            S_DISP:
            begin
                if (pend_reg && used_reg[pidx_reg] &&
                    (rd_mode == MODE_READY || rd_mode == MODE_RUN) &&
                    (!bfound_reg || rd_info.period < bper_reg))
                begin
                    bfound_next = 1'b1;
                    best_next   = pidx_reg;
                    bper_next   = rd_info.period;
                    bid_next    = rd_info.id;
                end
                if (scan_end)
                begin
                    if (!bfound_reg || (rvalid_reg && rslot_reg == best_reg))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SWAP1;
                    end
                end
            end
            S_SWAP1:
            begin
                // a valid running task is always in run mode
                mode_we    = rvalid_reg;
                mode_waddr = rslot_reg;
                mode_wdata = MODE_READY;
                state_next = S_SWAP2;
            end
            S_SWAP2:
            begin
                mode_we     = 1'b1;
                mode_waddr  = best_reg;
                mode_wdata  = MODE_RUN;
                rslot_next  = best_reg;
                rvalid_next = 1'b1;
                rid_next    = bid_reg;
                sw_next     = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    ovalid_next = 1'b1;
                    ost_next    = st_reg;
                    orv_next    = rvalid_reg;
                    oid_next    = rvalid_reg ? rid_reg : '0;
                    osw_next    = sw_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            used_reg   <= '0;
            rvalid_reg <= 1'b0;
            total_reg  <= '0;
            time_reg   <= '0;
            limit_reg  <= LIMIT_RESET;
            ovalid_reg <= 1'b0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            used_reg   <= used_next;
            rvalid_reg <= rvalid_next;
            total_reg  <= total_next;
            time_reg   <= time_next;
            limit_reg  <= limit_next;
            ovalid_reg <= ovalid_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        id_reg     <= id_next;
        per_reg    <= per_next;
        comp_reg   <= comp_next;
        cnt_reg    <= cnt_next;
        pidx_reg   <= pidx_next;
        found_reg  <= found_next;
        slot_reg   <= slot_next;
        ent_reg    <= ent_next;
        fmode_reg  <= fmode_next;
        bfound_reg <= bfound_next;
        best_reg   <= best_next;
        bper_reg   <= bper_next;
        bid_reg    <= bid_next;
        woke_reg   <= woke_next;
        share_reg  <= share_next;
        prod_reg   <= prod_next;
        rslot_reg  <= rslot_next;
        rid_reg    <= rid_next;
        st_reg     <= st_next;
        sw_reg     <= sw_next;
        ost_reg    <= ost_next;
        orv_reg    <= orv_next;
        oid_reg    <= oid_next;
        osw_reg    <= osw_next;
    end

    assign in_ready      = state_reg == S_IDLE;
    assign cfg_ready     = 1'b1;
    assign out_valid     = ovalid_reg;
    assign status        = ost_reg;
    assign running_valid = orv_reg;
    assign running_id    = oid_reg;
    assign switched      = osw_reg;

    `RMTS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "accepted while busy")
    `RMTS_ASSERT_NOW(a_switch_has_runner, clk, rst_n, out_valid && switched, running_valid, "switch without runner")
    `RMTS_ASSERT_NOW(a_runner_used, clk, rst_n, rvalid_reg, used_reg[rslot_reg], "running slot not in use")
    `RMTS_ASSERT_NOW(a_notfound_no_switch, clk, rst_n, out_valid && status == ST_NOTFOUND, !switched, "switch on unknown task")

endmodule
